// ===== design/softlj_pkg.sv =====
// ----------------------------------------------------------------------------
// softlj_pkg
// Shared sizes, codes, saturating Q32.32 helpers and the evaluation
// microprogram of the soft-core Lennard-Jones pair kernel.
// ----------------------------------------------------------------------------
package softlj_pkg;

   localparam int TYPE_PAIRS = 64;
   localparam int GRID       = 16;
   localparam int SLOTS      = GRID + 1;
   localparam int COEF_DEPTH = TYPE_PAIRS * SLOTS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int PT_AW      = $clog2(TYPE_PAIRS);
   localparam int NODE_AW    = $clog2(GRID);

   typedef logic signed [63:0] q_type;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_EVAL  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   localparam logic [2:0] SEL_CUTOFF = 3'd0;
   localparam logic [2:0] SEL_REP    = 3'd1;
   localparam logic [2:0] SEL_ATT    = 3'd2;
   localparam logic [2:0] SEL_SHIFT  = 3'd3;
   localparam logic [2:0] SEL_OFFSET = 3'd4;
   localparam logic [2:0] SEL_LINK   = 3'd5;

   localparam logic [2:0] CSR_WEIGHT_LAST = 3'd3;
   localparam logic [2:0] CSR_GRID_NODES  = 3'd4;

   localparam q_type Q_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam q_type Q_MIN    = 64'sh8000_0000_0000_0000;
   localparam q_type Q_TWELVE = 64'sh0000_000C_0000_0000;
   localparam q_type Q_SIX    = 64'sh0000_0006_0000_0000;

   localparam logic ARITH_MUL = 1'b0;
   localparam logic ARITH_RCP = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } arith_req_type;

   // Microprogram operation kinds.
   localparam logic [3:0] K_MUL    = 4'd0;
   localparam logic [3:0] K_RCP    = 4'd1;
   localparam logic [3:0] K_ADD    = 4'd2;
   localparam logic [3:0] K_SUB    = 4'd3;
   localparam logic [3:0] K_HALF   = 4'd4;
   localparam logic [3:0] K_ENCHK  = 4'd5;
   localparam logic [3:0] K_LNKCHK = 4'd6;
   localparam logic [3:0] K_READ   = 4'd7;
   localparam logic [3:0] K_CAPT   = 4'd8;
   localparam logic [3:0] K_ACCUM  = 4'd9;
   localparam logic [3:0] K_END    = 4'd10;

   // Operand sources.
   localparam logic [4:0] S_RSQ    = 5'd0;
   localparam logic [4:0] S_R6     = 5'd1;
   localparam logic [4:0] S_SINV   = 5'd2;
   localparam logic [4:0] S_REP    = 5'd3;
   localparam logic [4:0] S_ATT    = 5'd4;
   localparam logic [4:0] S_SHF    = 5'd5;
   localparam logic [4:0] S_OFF    = 5'd6;
   localparam logic [4:0] S_W      = 5'd7;
   localparam logic [4:0] S_T      = 5'd8;
   localparam logic [4:0] S_U      = 5'd9;
   localparam logic [4:0] S_FP     = 5'd10;
   localparam logic [4:0] S_DX     = 5'd11;
   localparam logic [4:0] S_DY     = 5'd12;
   localparam logic [4:0] S_DZ     = 5'd13;
   localparam logic [4:0] S_TWELVE = 5'd14;
   localparam logic [4:0] S_SIX    = 5'd15;
   localparam logic [4:0] S_NODE   = 5'd16;

   // Destinations.
   localparam logic [3:0] D_T    = 4'd0;
   localparam logic [3:0] D_U    = 4'd1;
   localparam logic [3:0] D_R6   = 4'd2;
   localparam logic [3:0] D_SINV = 4'd3;
   localparam logic [3:0] D_FP   = 4'd4;
   localparam logic [3:0] D_FX   = 4'd5;
   localparam logic [3:0] D_FY   = 4'd6;
   localparam logic [3:0] D_FZ   = 4'd7;
   localparam logic [3:0] D_EGY  = 4'd8;

   localparam logic [5:0] UPC_NODE = 6'd24;

   typedef struct packed {
      logic [3:0] kind;
      logic [4:0] a;
      logic [4:0] b;
      logic [3:0] dst;
   } uop_type;

   function automatic uop_type mk(logic [3:0] kind, logic [4:0] a, logic [4:0] b,
                                  logic [3:0] dst);
      uop_type u;
      u.kind = kind;
      u.a    = a;
      u.b    = b;
      u.dst  = dst;
      return u;
   endfunction

   // Force, then energy at the current lambda, then the grid node loop.
   function automatic uop_type uop_at(logic [5:0] pc);
      uop_type u;
      unique case (pc)
         6'd0:  u = mk(K_MUL, S_RSQ, S_RSQ, D_T);
         6'd1:  u = mk(K_MUL, S_T, S_RSQ, D_R6);
         6'd2:  u = mk(K_ADD, S_R6, S_SHF, D_T);
         6'd3:  u = mk(K_RCP, S_T, S_T, D_SINV);
         6'd4:  u = mk(K_MUL, S_REP, S_TWELVE, D_T);
         6'd5:  u = mk(K_MUL, S_T, S_SINV, D_T);
         6'd6:  u = mk(K_MUL, S_ATT, S_SIX, D_U);
         6'd7:  u = mk(K_SUB, S_T, S_U, D_T);
         6'd8:  u = mk(K_MUL, S_R6, S_SINV, D_U);
         6'd9:  u = mk(K_MUL, S_U, S_SINV, D_U);
         6'd10: u = mk(K_MUL, S_U, S_T, D_T);
         6'd11: u = mk(K_MUL, S_W, S_T, D_T);
         6'd12: u = mk(K_RCP, S_RSQ, S_RSQ, D_U);
         6'd13: u = mk(K_MUL, S_T, S_U, D_FP);
         6'd14: u = mk(K_MUL, S_DX, S_FP, D_FX);
         6'd15: u = mk(K_MUL, S_DY, S_FP, D_FY);
         6'd16: u = mk(K_MUL, S_DZ, S_FP, D_FZ);
         6'd17: u = mk(K_ENCHK, S_T, S_T, D_T);
         6'd18: u = mk(K_MUL, S_REP, S_SINV, D_T);
         6'd19: u = mk(K_SUB, S_T, S_ATT, D_T);
         6'd20: u = mk(K_MUL, S_SINV, S_T, D_T);
         6'd21: u = mk(K_SUB, S_T, S_OFF, D_T);
         6'd22: u = mk(K_MUL, S_W, S_T, D_EGY);
         6'd23: u = mk(K_LNKCHK, S_T, S_T, D_T);
         6'd24: u = mk(K_READ, S_T, S_T, D_T);
         6'd25: u = mk(K_CAPT, S_T, S_T, D_T);
         6'd26: u = mk(K_ADD, S_R6, S_SHF, D_T);
         6'd27: u = mk(K_RCP, S_T, S_T, D_SINV);
         6'd28: u = mk(K_MUL, S_REP, S_SINV, D_T);
         6'd29: u = mk(K_SUB, S_T, S_ATT, D_T);
         6'd30: u = mk(K_MUL, S_SINV, S_T, D_T);
         6'd31: u = mk(K_SUB, S_T, S_OFF, D_T);
         6'd32: u = mk(K_MUL, S_W, S_T, D_T);
         6'd33: u = mk(K_HALF, S_T, S_T, D_T);
         6'd34: u = mk(K_ADD, S_NODE, S_T, D_T);
         6'd35: u = mk(K_ACCUM, S_T, S_T, D_T);
         default: u = mk(K_END, S_T, S_T, D_T);
      endcase
      return u;
   endfunction

   function automatic q_type sat_add(q_type a, q_type b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return q_type'(s[63:0]);
   endfunction

   function automatic q_type sat_sub(q_type a, q_type b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return q_type'(s[63:0]);
   endfunction

   function automatic q_type signed_mag(logic [63:0] mag, logic neg, logic over);
      if (!neg) begin
         if (over || mag[63]) return Q_MAX;
         return q_type'(mag);
      end
      if (over || mag[63]) return Q_MIN;
      return q_type'(64'd0 - mag);
   endfunction

endpackage

// ===== design/softlj_ram.sv =====
// ----------------------------------------------------------------------------
// softlj_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module softlj_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/softlj_arith.sv =====
// ----------------------------------------------------------------------------
// softlj_arith
// Shared Q32.32 unit: saturating multiply over four 32x32 partial products,
// and a reciprocal 2^64/|d| by restoring division, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module softlj_arith (
   input  logic                      clock,
   input  logic                      reset,
   input  softlj_pkg::arith_req_type req,
   input  softlj_pkg::q_type         a,
   input  softlj_pkg::q_type         b,
   output logic                      done,
   output softlj_pkg::q_type         result
);
   import softlj_pkg::*;

   logic         busy_ff, busy_in;
   logic         op_ff, op_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [63:0]  ua_ff, ua_in, ub_ff, ub_in;
   logic         neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [64:0]  rem_ff, rem_in;
   logic [63:0]  quo_ff, quo_in;
   logic         done_ff, done_in;
   q_type        result_ff, result_in;

   logic [31:0]  pa, pb;
   logic [63:0]  part;
   logic [127:0] part_sh;
   logic [64:0]  rem_sh;
   logic [63:0]  mag_a, mag_b;

   assign mag_a = a[63] ? 64'd0 - a : a;
   assign mag_b = b[63] ? 64'd0 - b : b;

   always_comb begin
      pa      = cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      pb      = cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      part    = pa * pb;
      part_sh = {64'd0, part} << (32 * (32'(cnt_ff[1]) + 32'(cnt_ff[0])));
      rem_sh  = {rem_ff[63:0], 1'b0};

      busy_in   = busy_ff;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      ua_in     = ua_ff;
      ub_in     = ub_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      done_in   = 1'b0;
      result_in = result_ff;

      if (req.start) begin
         op_in  = req.op;
         cnt_in = '0;
         ua_in  = mag_a;
         ub_in  = mag_b;
         acc_in = '0;
         rem_in = 65'd1;
         quo_in = '0;
         if (req.op == ARITH_MUL) begin
            neg_in  = a[63] ^ b[63];
            busy_in = 1'b1;
         end else begin
            neg_in = a[63];
            if (a == '0) begin
               result_in = Q_MAX;
               done_in   = 1'b1;
            end else if (mag_a == 64'd1) begin
               result_in = signed_mag(64'd0, a[63], 1'b1);
               done_in   = 1'b1;
            end else begin
               busy_in = 1'b1;
            end
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (op_ff == ARITH_MUL) begin
            acc_in = acc_ff + part_sh;
            if (cnt_ff == 6'd3) begin
               busy_in   = 1'b0;
               done_in   = 1'b1;
               result_in = signed_mag(acc_in[95:32], neg_ff, acc_in[127:96] != '0);
            end
         end else begin
            if (rem_sh >= {1'b0, ub_ff}) begin
               rem_in = rem_sh - {1'b0, ub_ff};
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[62:0], 1'b0};
            end
            if (cnt_ff == 6'd63) begin
               busy_in   = 1'b0;
               done_in   = 1'b1;
               result_in = signed_mag(quo_in, neg_ff, 1'b0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== design/softcore_lj_pair_kernel.sv =====
// ----------------------------------------------------------------------------
// softcore_lj_pair_kernel
// Soft-core Lennard-Jones 12-6 pair kernel with per-lambda-node energies.
// ----------------------------------------------------------------------------
// The kernel handles one transaction at a time. Load and clear transactions
// go from fetch to done, and a read adds a capture state. An evaluate
// transaction captures its coefficients, sums the squared displacement and
// compares it with the cutoff; one in range then runs a microprogram on a
// shared Q32.32 unit, whose reciprocals come from a restoring divider that
// makes one quotient bit a cycle. The force part comes first; with energy on,
// energy at the current lambda follows, and a linked pair adds one pass per
// grid node. Per-slot coefficients live in synchronous RAMs indexed by type
// pair times seventeen plus slot, cutoff and link by type pair alone; the grid
// node accumulators live in a sixteen-entry RAM whose valid bits are cleared
// by reset and by a clear transaction, so an accumulator that was never
// written reads as zero. A finished result sits in an output register, so the
// next transaction is taken while it waits to be picked up.
// ----------------------------------------------------------------------------
module softcore_lj_pair_kernel (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic [5:0]          req_pair_type,
   input  logic [4:0]          req_slot,
   input  logic [2:0]          req_coef_select,
   input  logic signed [63:0]  req_load_value,
   input  logic signed [31:0]  req_dx,
   input  logic signed [31:0]  req_dy,
   input  logic signed [31:0]  req_dz,
   input  logic [1:0]          req_bond_class,
   input  logic                req_full_weight,
   input  logic                req_energy_on,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_in_range,
   output logic signed [63:0]  rsp_pair_scale,
   output logic signed [63:0]  rsp_force_x,
   output logic signed [63:0]  rsp_force_y,
   output logic signed [63:0]  rsp_force_z,
   output logic signed [63:0]  rsp_pair_energy,
   output logic signed [63:0]  rsp_read_data,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [16:0]         csr_data
);
   import softlj_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_CAPT  = 3'd2;
   localparam logic [2:0] ST_SQ    = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;
   localparam logic [2:0] ST_EXEC  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]  state_ff;
   logic        rsp_valid_ff;
   logic        issued_ff;
   logic [GRID-1:0] node_valid_ff;
   logic [16:0] weight_ff [4];
   logic [4:0]  nodes_ff;

   // Latched transaction fields.
   logic [1:0]  func_ff;
   logic [5:0]  pt_ff;
   logic [4:0]  slot_ff;
   logic [2:0]  sel_ff;
   q_type       value_ff;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;
   logic        full_ff, eon_ff;

   // Operand and result registers.
   q_type       rsq_ff, cut_ff, rep_ff, att_ff, shf_ff, off_ff, node_ff, w_ff;
   q_type       t_ff, u_ff, r6_ff, sinv_ff, fp_ff, fx_ff, fy_ff, fz_ff, egy_ff, rd_ff;
   logic [1:0]  link_ff;
   logic        inr_ff;
   logic [63:0] sum_ff;
   logic [1:0]  sq_cnt_ff;
   logic [5:0]  pc_ff;
   logic [4:0]  k_ff;

   logic        rsp_in_range_ff;
   q_type       rsp_scale_ff, rsp_fx_ff, rsp_fy_ff, rsp_fz_ff, rsp_egy_ff, rsp_rd_ff;

   // RAM ports.
   logic [COEF_AW-1:0] coef_base, coef_waddr, coef_raddr;
   logic               cut_we, link_we, rep_we, att_we, shf_we, off_we, node_we;
   logic [63:0]        cut_rdata, rep_rdata, att_rdata, shf_rdata, off_rdata, node_rdata;
   logic [1:0]         link_rdata;
   logic [NODE_AW-1:0] node_raddr;

   uop_type       uop;
   arith_req_type arith_req;
   logic          arith_done;
   q_type         arith_result;
   q_type         opa, opb;
   logic [4:0]    nodes_used;
   logic          in_accept, out_free, load_go, slot_ok;
   logic signed [31:0] sq_src;
   logic signed [63:0] sq_val;
   logic [63:0]   sum_next;

   function automatic q_type pick(logic [4:0] s);
      unique case (s)
         S_RSQ:    return rsq_ff;
         S_R6:     return r6_ff;
         S_SINV:   return sinv_ff;
         S_REP:    return rep_ff;
         S_ATT:    return att_ff;
         S_SHF:    return shf_ff;
         S_OFF:    return off_ff;
         S_W:      return w_ff;
         S_T:      return t_ff;
         S_U:      return u_ff;
         S_FP:     return fp_ff;
         S_DX:     return {{24{dx_ff[31]}}, dx_ff, 8'd0};
         S_DY:     return {{24{dy_ff[31]}}, dy_ff, 8'd0};
         S_DZ:     return {{24{dz_ff[31]}}, dz_ff, 8'd0};
         S_TWELVE: return Q_TWELVE;
         S_SIX:    return Q_SIX;
         S_NODE:   return node_ff;
         default:  return '0;
      endcase
   endfunction

   assign uop        = uop_at(pc_ff);
   assign opa        = pick(uop.a);
   assign opb        = pick(uop.b);
   assign in_accept  = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign nodes_used = (nodes_ff > 5'(GRID)) ? 5'(GRID) : nodes_ff;

   assign arith_req = '{start: (state_ff == ST_EXEC) && !issued_ff &&
                               ((uop.kind == K_MUL) || (uop.kind == K_RCP)),
                        op:    (uop.kind == K_RCP) ? ARITH_RCP : ARITH_MUL};

   // Coefficient addressing: type pair times the slot count, plus slot.
   assign coef_base  = COEF_AW'(pt_ff) * COEF_AW'(SLOTS);
   assign coef_waddr = coef_base + COEF_AW'(slot_ff);
   assign coef_raddr = (state_ff == ST_EXEC) ? coef_base + COEF_AW'(k_ff) + COEF_AW'(1)
                                             : coef_base;
   assign node_raddr = (state_ff == ST_EXEC) ? k_ff[NODE_AW-1:0]
                                             : NODE_AW'(slot_ff - 5'd1);

   assign load_go = (state_ff == ST_FETCH) && (func_ff == FUNC_LOAD);
   assign slot_ok = (slot_ff <= 5'(GRID));
   assign cut_we  = load_go && (sel_ff == SEL_CUTOFF);
   assign link_we = load_go && (sel_ff == SEL_LINK);
   assign rep_we  = load_go && slot_ok && (sel_ff == SEL_REP);
   assign att_we  = load_go && slot_ok && (sel_ff == SEL_ATT);
   assign shf_we  = load_go && slot_ok && (sel_ff == SEL_SHIFT);
   assign off_we  = load_go && slot_ok && (sel_ff == SEL_OFFSET);
   assign node_we = (state_ff == ST_EXEC) && (uop.kind == K_ACCUM);

   // Squared distance, one component a cycle.
   always_comb begin
      unique case (sq_cnt_ff)
         2'd0:    sq_src = dx_ff;
         2'd1:    sq_src = dy_ff;
         default: sq_src = dz_ff;
      endcase
      sq_val   = sq_src * sq_src;
      sum_next = sum_ff + 64'(sq_val);
   end

   softlj_ram #(.WIDTH(64), .DEPTH(TYPE_PAIRS)) u_cut (
      .clock(clock), .we(cut_we), .waddr(pt_ff), .wdata(value_ff),
      .raddr(pt_ff), .rdata(cut_rdata));
   softlj_ram #(.WIDTH(2), .DEPTH(TYPE_PAIRS)) u_link (
      .clock(clock), .we(link_we), .waddr(pt_ff), .wdata(value_ff[1:0]),
      .raddr(pt_ff), .rdata(link_rdata));
   softlj_ram #(.WIDTH(64), .DEPTH(COEF_DEPTH)) u_rep (
      .clock(clock), .we(rep_we), .waddr(coef_waddr), .wdata(value_ff),
      .raddr(coef_raddr), .rdata(rep_rdata));
   softlj_ram #(.WIDTH(64), .DEPTH(COEF_DEPTH)) u_att (
      .clock(clock), .we(att_we), .waddr(coef_waddr), .wdata(value_ff),
      .raddr(coef_raddr), .rdata(att_rdata));
   softlj_ram #(.WIDTH(64), .DEPTH(COEF_DEPTH)) u_shf (
      .clock(clock), .we(shf_we), .waddr(coef_waddr), .wdata(value_ff),
      .raddr(coef_raddr), .rdata(shf_rdata));
   softlj_ram #(.WIDTH(64), .DEPTH(COEF_DEPTH)) u_off (
      .clock(clock), .we(off_we), .waddr(coef_waddr), .wdata(value_ff),
      .raddr(coef_raddr), .rdata(off_rdata));
   softlj_ram #(.WIDTH(64), .DEPTH(GRID)) u_node (
      .clock(clock), .we(node_we), .waddr(k_ff[NODE_AW-1:0]), .wdata(t_ff),
      .raddr(node_raddr), .rdata(node_rdata));

   softlj_arith u_arith (
      .clock(clock), .reset(reset), .req(arith_req), .a(opa), .b(opb),
      .done(arith_done), .result(arith_result));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         issued_ff     <= 1'b0;
         node_valid_ff <= '0;
         weight_ff[0]  <= 17'd65536;
         weight_ff[1]  <= '0;
         weight_ff[2]  <= '0;
         weight_ff[3]  <= '0;
         nodes_ff      <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index <= CSR_WEIGHT_LAST) begin
               weight_ff[csr_index[1:0]] <= csr_data;
            end else if (csr_index == CSR_GRID_NODES) begin
               nodes_ff <= csr_data[4:0];
            end
         end

         // The done state reloads the output register in the same cycle.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (in_accept) begin
                  func_ff  <= req_func;
                  pt_ff    <= req_pair_type;
                  slot_ff  <= req_slot;
                  sel_ff   <= req_coef_select;
                  value_ff <= req_load_value;
                  dx_ff    <= req_dx;
                  dy_ff    <= req_dy;
                  dz_ff    <= req_dz;
                  full_ff  <= req_full_weight;
                  eon_ff   <= req_energy_on;
                  w_ff     <= q_type'({weight_ff[req_bond_class], 16'd0});
                  inr_ff   <= 1'b0;
                  fp_ff    <= '0;
                  fx_ff    <= '0;
                  fy_ff    <= '0;
                  fz_ff    <= '0;
                  egy_ff   <= '0;
                  rd_ff    <= '0;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               // Loads are written this cycle; reads land in the next one.
               sum_ff    <= '0;
               sq_cnt_ff <= '0;
               if (func_ff == FUNC_CLEAR) begin
                  node_valid_ff <= '0;
               end
               if ((func_ff == FUNC_EVAL) || (func_ff == FUNC_READ)) begin
                  state_ff <= ST_CAPT;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_CAPT: begin
               if (func_ff == FUNC_READ) begin
                  if ((slot_ff != 5'd0) && slot_ok && node_valid_ff[node_raddr]) begin
                     rd_ff <= node_rdata;
                  end
                  state_ff <= ST_DONE;
               end else begin
                  cut_ff   <= cut_rdata;
                  link_ff  <= link_rdata;
                  rep_ff   <= rep_rdata;
                  att_ff   <= att_rdata;
                  shf_ff   <= shf_rdata;
                  off_ff   <= off_rdata;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               sum_ff    <= sum_next;
               sq_cnt_ff <= sq_cnt_ff + 2'd1;
               if (sq_cnt_ff == 2'd2) begin
                  rsq_ff   <= q_type'({16'd0, sum_next[63:16]});
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               pc_ff     <= '0;
               issued_ff <= 1'b0;
               if (rsq_ff < cut_ff) begin
                  inr_ff   <= 1'b1;
                  state_ff <= ST_EXEC;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_EXEC: begin
               priority case (uop.kind)
                  K_MUL, K_RCP: begin
                     if (arith_req.start) begin
                        issued_ff <= 1'b1;
                     end
                     if (arith_done) begin
                        issued_ff <= 1'b0;
                        pc_ff     <= pc_ff + 6'd1;
                        unique case (uop.dst)
                           D_T:     t_ff    <= arith_result;
                           D_U:     u_ff    <= arith_result;
                           D_R6:    r6_ff   <= arith_result;
                           D_SINV:  sinv_ff <= arith_result;
                           D_FP:    fp_ff   <= arith_result;
                           D_FX:    fx_ff   <= arith_result;
                           D_FY:    fy_ff   <= arith_result;
                           D_FZ:    fz_ff   <= arith_result;
                           D_EGY:   egy_ff  <= arith_result;
                           default: t_ff    <= arith_result;
                        endcase
                     end
                  end
                  K_ADD: begin
                     t_ff  <= sat_add(opa, opb);
                     pc_ff <= pc_ff + 6'd1;
                  end
                  K_SUB: begin
                     t_ff  <= sat_sub(opa, opb);
                     pc_ff <= pc_ff + 6'd1;
                  end
                  K_HALF: begin
                     // Ghost pairs count half, rounding toward minus infinity.
                     if (!full_ff) begin
                        t_ff <= t_ff >>> 1;
                     end
                     pc_ff <= pc_ff + 6'd1;
                  end
                  K_ENCHK: begin
                     if (eon_ff) begin
                        pc_ff <= pc_ff + 6'd1;
                     end else begin
                        state_ff <= ST_DONE;
                     end
                  end
                  K_LNKCHK: begin
                     k_ff <= '0;
                     if ((link_ff == 2'd0) || (nodes_used == 5'd0)) begin
                        state_ff <= ST_DONE;
                     end else begin
                        pc_ff <= pc_ff + 6'd1;
                     end
                  end
                  K_READ: begin
                     pc_ff <= pc_ff + 6'd1;
                  end
                  K_CAPT: begin
                     rep_ff  <= rep_rdata;
                     att_ff  <= att_rdata;
                     shf_ff  <= shf_rdata;
                     off_ff  <= off_rdata;
                     node_ff <= node_valid_ff[node_raddr] ? q_type'(node_rdata) : '0;
                     pc_ff   <= pc_ff + 6'd1;
                  end
                  K_ACCUM: begin
                     node_valid_ff[k_ff[NODE_AW-1:0]] <= 1'b1;
                     if (k_ff + 5'd1 < nodes_used) begin
                        k_ff  <= k_ff + 5'd1;
                        pc_ff <= UPC_NODE;
                     end else begin
                        state_ff <= ST_DONE;
                     end
                  end
                  default: begin
                     state_ff <= ST_DONE;
                  end
               endcase
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_in_range_ff <= inr_ff;
                  rsp_scale_ff    <= fp_ff;
                  rsp_fx_ff       <= fx_ff;
                  rsp_fy_ff       <= fy_ff;
                  rsp_fz_ff       <= fz_ff;
                  rsp_egy_ff      <= egy_ff;
                  rsp_rd_ff       <= rd_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_in_range    = rsp_in_range_ff;
   assign rsp_pair_scale  = rsp_scale_ff;
   assign rsp_force_x     = rsp_fx_ff;
   assign rsp_force_y     = rsp_fy_ff;
   assign rsp_force_z     = rsp_fz_ff;
   assign rsp_pair_energy = rsp_egy_ff;
   assign rsp_read_data   = rsp_rd_ff;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Soft-core Lennard-Jones pair kernel testbench
// Loads the coefficient tables of the pair types in use and then drives
// directed and random load, evaluate, clear and read transactions through the
// kernel under random idle bursts on both sides. A bit-exact fixed-point
// predictor checks each result.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import softlj_pkg::*;

   localparam logic [2:0] CSR_WEIGHT_FIRST = 3'd0;
   // Pair types whose tables are filled; evaluations only use these.
   localparam int FILL_PAIRS = 8;

   // One input transaction, field by field.
   typedef struct {
      logic [1:0]         func;
      logic [5:0]         pt;
      logic [4:0]         slot;
      logic [2:0]         sel;
      logic signed [63:0] value;
      logic signed [31:0] dx, dy, dz;
      logic [1:0]         bond;
      logic               full;
      logic               energy;
   } pair_item_type;

   // One result transaction.
   typedef struct packed {
      logic               in_range;
      logic signed [63:0] scale, fx, fy, fz, energy, rdata;
   } pair_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = '0;
   logic [5:0]         req_pair_type = '0;
   logic [4:0]         req_slot = '0;
   logic [2:0]         req_coef_select = '0;
   logic signed [63:0] req_load_value = '0;
   logic signed [31:0] req_dx = '0, req_dy = '0, req_dz = '0;
   logic [1:0]         req_bond_class = '0;
   logic               req_full_weight = 1'b0;
   logic               req_energy_on = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_in_range;
   logic signed [63:0] rsp_pair_scale, rsp_force_x, rsp_force_y, rsp_force_z;
   logic signed [63:0] rsp_pair_energy, rsp_read_data;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [16:0]        csr_data = '0;

   softcore_lj_pair_kernel dut (.*);

   always #2 clock = ~clock;

   // Shadow copy of the kernel state used by the predictor.
   logic signed [63:0] cutoff_shadow [TYPE_PAIRS];
   logic [1:0]         link_shadow   [TYPE_PAIRS];
   logic signed [63:0] rep_shadow    [COEF_DEPTH];
   logic signed [63:0] att_shadow    [COEF_DEPTH];
   logic signed [63:0] shift_shadow  [COEF_DEPTH];
   logic signed [63:0] offset_shadow [COEF_DEPTH];
   logic signed [63:0] node_sum      [GRID];
   logic [16:0]        weight_reg    [4];
   logic [4:0]         nodes_reg;

   pair_result_type expected_results [$];

   int  mismatches = 0;
   int  n_items = 0, n_evals = 0, n_hits = 0, n_checked = 0;
   bit  quiet = 1'b0;   // no idle bursts in the last part of the run

   // ----------------------------------------------------------------------
   // Q32.32 arithmetic, saturating.
   // ----------------------------------------------------------------------
   function automatic logic signed [63:0] clamp_mag(logic [63:0] mag, logic neg, logic over);
      if (!neg)
         return (over || mag[63]) ? Q_MAX : $signed(mag);
      return (over || mag[63]) ? Q_MIN : $signed(64'd0 - mag);
   endfunction

   function automatic logic signed [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b);
      logic [63:0]  ma, mb;
      logic [127:0] p;
      ma = a[63] ? 64'd0 - a : a;
      mb = b[63] ? 64'd0 - b : b;
      p = {64'd0, ma} * {64'd0, mb};
      return clamp_mag(p[95:32], a[63] ^ b[63], |p[127:96]);
   endfunction

   function automatic logic signed [63:0] fx_recip(logic signed [63:0] d);
      logic [63:0] m;
      logic [64:0] q;
      if (d == 0) return Q_MAX;
      m = d[63] ? 64'd0 - d : d;
      if (m == 64'd1) return d[63] ? Q_MIN : Q_MAX;
      q = {1'b1, 64'd0} / {1'b0, m};
      return clamp_mag(q[63:0], d[63], 1'b0);
   endfunction

   function automatic logic signed [63:0] fx_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(Q_MAX)) return Q_MAX;
      if (s < 65'(Q_MIN)) return Q_MIN;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] fx_sub(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) - 65'(b);
      if (s > 65'(Q_MAX)) return Q_MAX;
      if (s < 65'(Q_MIN)) return Q_MIN;
      return s[63:0];
   endfunction

   // Weighted shifted energy: w * (sinv * (rep * sinv - att) - off).
   function automatic logic signed [63:0] lj_energy(logic signed [63:0] w,
         logic signed [63:0] sinv, logic signed [63:0] rep, logic signed [63:0] att,
         logic signed [63:0] off);
      logic signed [63:0] t;
      t = fx_sub(fx_mul(rep, sinv), att);
      return fx_mul(w, fx_sub(fx_mul(sinv, t), off));
   endfunction

   // Applies one transaction to the shadow state and returns the result.
   function automatic pair_result_type pair_outcome(pair_item_type it);
      pair_result_type r;
      int                 base, ix, nodes;
      logic signed [63:0] sx, sy, sz, rsq, w, r6, rep, att, sinv, t, flj, fp, sk, ek;
      logic [63:0]        sum;
      r = '0;
      case (it.func)
         FUNC_LOAD: begin
            if (it.sel == SEL_CUTOFF) cutoff_shadow[it.pt] = it.value;
            else if (it.sel == SEL_LINK) link_shadow[it.pt] = it.value[1:0];
            else if (it.sel < SEL_LINK && it.slot <= GRID) begin
               ix = it.pt * SLOTS + it.slot;
               case (it.sel)
                  SEL_REP:   rep_shadow[ix] = it.value;
                  SEL_ATT:   att_shadow[ix] = it.value;
                  SEL_SHIFT: shift_shadow[ix] = it.value;
                  default:   offset_shadow[ix] = it.value;
               endcase
            end
         end
         FUNC_CLEAR: foreach (node_sum[k]) node_sum[k] = '0;
         FUNC_READ: if (it.slot >= 1 && it.slot <= GRID) r.rdata = node_sum[it.slot - 1];
         default: begin
            sx = it.dx; sy = it.dy; sz = it.dz;
            sum = sx * sx + sy * sy + sz * sz;
            rsq = $signed(sum >> 16);
            if (rsq < cutoff_shadow[it.pt]) begin
               base = it.pt * SLOTS;
               w    = 64'(weight_reg[it.bond]) << 16;
               r6   = fx_mul(fx_mul(rsq, rsq), rsq);
               rep  = rep_shadow[base];
               att  = att_shadow[base];
               sinv = fx_recip(fx_add(r6, shift_shadow[base]));
               t    = fx_sub(fx_mul(fx_mul(rep, Q_TWELVE), sinv), fx_mul(att, Q_SIX));
               flj  = fx_mul(fx_mul(fx_mul(r6, sinv), sinv), t);
               fp   = fx_mul(fx_mul(w, flj), fx_recip(rsq));
               r.in_range = 1'b1;
               r.scale = fp;
               r.fx = fx_mul(sx <<< 8, fp);
               r.fy = fx_mul(sy <<< 8, fp);
               r.fz = fx_mul(sz <<< 8, fp);
               if (it.energy) begin
                  r.energy = lj_energy(w, sinv, rep, att, offset_shadow[base]);
                  nodes = (nodes_reg > GRID) ? GRID : nodes_reg;
                  if (link_shadow[it.pt] != 2'd0) begin
                     for (int k = 0; k < nodes; k++) begin
                        ix = base + k + 1;
                        sk = fx_recip(fx_add(r6, shift_shadow[ix]));
                        ek = lj_energy(w, sk, rep_shadow[ix], att_shadow[ix],
                                       offset_shadow[ix]);
                        if (!it.full) ek = ek >>> 1;
                        node_sum[k] = fx_add(node_sum[k], ek);
                     end
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   // ----------------------------------------------------------------------
   // Driving.
   // ----------------------------------------------------------------------

   // Sends one transaction, possibly after an idle burst, and records what
   // the kernel should answer once the handshake completes.
   task automatic send_item(pair_item_type it);
      bit taken;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= it.func;
      req_pair_type   <= it.pt;
      req_slot        <= it.slot;
      req_coef_select <= it.sel;
      req_load_value  <= it.value;
      req_dx          <= it.dx;
      req_dy          <= it.dy;
      req_dz          <= it.dz;
      req_bond_class  <= it.bond;
      req_full_weight <= it.full;
      req_energy_on   <= it.energy;
      // Stall is sampled at the falling edge, where it is settled.
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      expected_results.push_back(pair_outcome(it));
      n_items++;
      if (it.func == FUNC_EVAL) n_evals++;
   endtask

   // Lowers valid and waits until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [16:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx <= CSR_WEIGHT_LAST) weight_reg[idx[1:0]] = val;
      else if (idx == CSR_GRID_NODES) nodes_reg = val[4:0];
      @(posedge clock);
   endtask

   function automatic pair_item_type blank_item(logic [1:0] func);
      pair_item_type it;
      it = '{default: '0};
      it.func = func;
      it.bond = 2'($urandom_range(0, 3));
      it.full = 1'($urandom);
      it.energy = 1'($urandom);
      return it;
   endfunction

   function automatic logic signed [63:0] coef_value(logic [2:0] sel);
      logic signed [63:0] v;
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      v = {32'd0, $urandom};
      case (sel)
         SEL_CUTOFF: v = v + (64'($urandom_range(0, 120)) << 32);
         SEL_SHIFT:  v = v + (64'($urandom_range(0, 3)) << 32);
         default:    v = v + (64'($urandom_range(0, 6)) << 32) - (64'd3 << 32);
      endcase
      return v;
   endfunction

   // Mostly a few units (Q8.24), now and then anything at all.
   function automatic logic signed [31:0] disp_value();
      if ($urandom_range(0, 15) == 0) return $urandom;
      return $signed(32'($urandom_range(0, 32'h1000_0000))) - 32'sh0800_0000;
   endfunction

   function automatic pair_item_type load_item(logic [5:0] pt, logic [4:0] slot,
                                               logic [2:0] sel);
      pair_item_type it;
      it = blank_item(FUNC_LOAD);
      it.pt = pt; it.slot = slot; it.sel = sel;
      it.value = (sel == SEL_LINK) ? 64'($signed($urandom_range(0, 2)) - 1) : coef_value(sel);
      return it;
   endfunction

   function automatic pair_item_type eval_item();
      pair_item_type it;
      it = blank_item(FUNC_EVAL);
      it.pt = 6'($urandom_range(0, FILL_PAIRS - 1));
      it.dx = disp_value(); it.dy = disp_value(); it.dz = disp_value();
      it.energy = ($urandom_range(0, 2) == 0);
      return it;
   endfunction

   // ----------------------------------------------------------------------
   // Tests.
   // ----------------------------------------------------------------------

   // Every table entry of the pair types in use is loaded once, so no
   // evaluation reads an unwritten one.
   task automatic test_table_fill();
      for (int p = 0; p < FILL_PAIRS; p++) begin
         send_item(load_item(6'(p), 5'($urandom), SEL_CUTOFF));
         send_item(load_item(6'(p), 5'($urandom), SEL_LINK));
         for (int s = 0; s <= GRID; s++)
            for (int sel = SEL_REP; sel <= SEL_OFFSET; sel++)
               send_item(load_item(6'(p), 5'(s), 3'(sel)));
      end
      drain();
   endtask

   task automatic test_registers();
      write_reg(CSR_WEIGHT_FIRST, 17'd65536);
      write_reg(CSR_WEIGHT_FIRST + 3'd1, 17'd0);
      write_reg(CSR_WEIGHT_FIRST + 3'd2, 17'd32768);
      write_reg(CSR_WEIGHT_LAST, 17'd65535);
      write_reg(CSR_GRID_NODES, 17'd16);
   endtask

   task automatic test_directed();
      pair_item_type it;
      // Zero displacement: the reciprocal of zero saturates high.
      it = eval_item(); it.pt = 6'd0; it.dx = 0; it.dy = 0; it.dz = 0;
      it.energy = 1'b1; it.full = 1'b0; send_item(it);
      // Extreme displacements on every axis.
      it = eval_item(); it.dx = 32'sh7FFF_FFFF; it.dy = 32'sh8000_0000;
      it.dz = 32'sh8000_0000; send_item(it);
      it = eval_item(); it.pt = 6'd7; it.dx = -1; it.dy = 1; it.dz = -1;
      it.energy = 1'b1; it.full = 1'b1; send_item(it);
      // A cutoff of the most negative value is never reached.
      it = load_item(6'd7, 5'd0, SEL_CUTOFF); it.value = Q_MIN; send_item(it);
      it = eval_item(); it.pt = 6'd7; it.dx = 0; it.dy = 0; it.dz = 0; send_item(it);
      // Large cutoff, link written as minus one, every weight class.
      it = load_item(6'd5, 5'd31, SEL_CUTOFF); it.value = Q_MAX; send_item(it);
      it = load_item(6'd5, 5'd0, SEL_LINK); it.value = -1; send_item(it);
      for (int b = 0; b < 4; b++) begin
         it = eval_item(); it.pt = 6'd5; it.bond = 2'(b); it.energy = 1'b1;
         it.full = 1'(b); send_item(it);
      end
      // Loads that must be ignored: slot past the grid and unknown selects.
      it = load_item(6'd5, 5'd17, SEL_REP); it.value = Q_MAX; send_item(it);
      it = load_item(6'd5, 5'd31, SEL_OFFSET); it.value = Q_MIN; send_item(it);
      it = load_item(6'd5, 5'd1, 3'd6); it.value = Q_MAX; send_item(it);
      it = load_item(6'd5, 5'd1, 3'd7); it.value = Q_MIN; send_item(it);
      it = eval_item(); it.pt = 6'd5; it.energy = 1'b1; send_item(it);
      // Reads of every kind of slot, then a clear and a read after it.
      for (int s = 0; s < 4; s++) begin
         it = blank_item(FUNC_READ);
         it.slot = (s == 0) ? 5'd0 : (s == 1) ? 5'd1 : (s == 2) ? 5'd16 : 5'd31;
         send_item(it);
      end
      send_item(blank_item(FUNC_CLEAR));
      it = blank_item(FUNC_READ); it.slot = 5'd1; send_item(it);
   endtask

   // Random traffic in phases, each with its own register setting.
   task automatic test_random(int count);
      pair_item_type it;
      int         phase_len, choice;
      logic [4:0] node_opts [6] = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd4};
      phase_len = count / 8;
      for (int n = 0; n < count; n++) begin
         if (n % phase_len == 0) begin
            // The sender holds off here until every expected result is in.
            drain();
            for (int i = 0; i < 4; i++)
               write_reg(CSR_WEIGHT_FIRST + 3'(i),
                         ($urandom_range(0, 3) == 0) ? 17'd65536 :
                         ($urandom_range(0, 3) == 0) ? 17'd0 : 17'($urandom_range(0, 65536)));
            write_reg(CSR_GRID_NODES, 17'(node_opts[$urandom_range(0, 5)]));
         end
         if (n == count - count / 8) quiet = 1'b1;
         choice = $urandom_range(0, 99);
         if (choice < 65) it = eval_item();
         else if (choice < 82) begin
            it = load_item(6'($urandom), 5'($urandom_range(0, 16)),
                           3'($urandom_range(0, 5)));
            if ($urandom_range(0, 7) == 0) begin
               it.slot = 5'($urandom);
               it.sel = 3'($urandom);
               it.value = {$urandom, $urandom};
            end
         end else if (choice < 95) begin
            it = blank_item(FUNC_READ);
            it.slot = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
         end else it = blank_item(FUNC_CLEAR);
         send_item(it);
      end
   endtask

   // ----------------------------------------------------------------------
   // Result side: random stall bursts, with calm stretches between them.
   // ----------------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 9) == 0 && ($time / 4000) % 3 != 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // A result is taken at the next rising edge when valid and not stalled at
   // the falling edge before it, so it is compared here.
   always @(negedge clock) begin
      pair_result_type exp_r;
      pair_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_in_range, rsp_pair_scale, rsp_force_x, rsp_force_y, rsp_force_z,
                 rsp_pair_energy, rsp_read_data};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction at %0t", $time);
         end else begin
            exp_r = expected_results.pop_front();
            n_checked++;
            if (got.in_range) n_hits++;
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t", $time);
                  $display("  expected in=%0d scale=%h f=%h %h %h e=%h rd=%h",
                           exp_r.in_range, exp_r.scale, exp_r.fx, exp_r.fy, exp_r.fz,
                           exp_r.energy, exp_r.rdata);
                  $display("  actual   in=%0d scale=%h f=%h %h %h e=%h rd=%h",
                           got.in_range, got.scale, got.fx, got.fy, got.fz,
                           got.energy, got.rdata);
               end
            end
         end
      end
   end

   initial begin
      #(400_000_000);
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      weight_reg = '{17'd65536, 17'd0, 17'd0, 17'd0};
      nodes_reg = '0;
      foreach (node_sum[k]) node_sum[k] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill();
      test_registers();
      test_directed();
      test_random(660);
      drain();
      if (expected_results.size() != 0) mismatches++;
      $display("Checked %0d results from %0d transactions, %0d evaluations, %0d in range.",
               n_checked, n_items, n_evals, n_hits);
      $display("Covered table loads, ignored loads, clears, reads and register phases.");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
